[design/krwlt_pkg.sv]
// ----------------------------------------------------------------------------
// krwlt_pkg
// Shared types and codes for the keyed reader/writer lock table.
// ----------------------------------------------------------------------------
package krwlt_pkg;

  // fixed port widths
  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned CNT_PORT_W = 16;

  // request opcodes
  localparam logic [1:0] OP_RD_LOCK   = 2'd0;
  localparam logic [1:0] OP_WR_LOCK   = 2'd1;
  localparam logic [1:0] OP_RD_UNLOCK = 2'd2;
  localparam logic [1:0] OP_WR_UNLOCK = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_CONFLICT = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_LIMIT    = 3'd3;
  localparam logic [2:0] ST_NOT_HELD = 3'd4;

  typedef enum logic [2:0] {
    KRWLT_CLEAR,
    KRWLT_IDLE,
    KRWLT_SCAN,
    KRWLT_DRAIN,
    KRWLT_EXEC
  } krwlt_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch request, restart scan
    logic clear;  // invalidate entry at scan address
    logic scan;   // issue table read at scan address
    logic exec;   // decide, update state, register result
  } krwlt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;  // scan address is at the last entry
  } krwlt_stat_t;

endpackage

[design/krwlt_ctrl.sv]
// ----------------------------------------------------------------------------
// krwlt_ctrl
// Sequencer for table clearing, key scan and request execution.
// ----------------------------------------------------------------------------
module krwlt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   is_global_i,
  input  krwlt_pkg::krwlt_stat_t stat_i,
  output krwlt_pkg::krwlt_cmd_t  cmd_o,
  output logic                   busy_o
);
  import krwlt_pkg::*;

  krwlt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KRWLT_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      KRWLT_CLEAR: begin
        if (stat_i.addr_last) begin
          state_d = KRWLT_IDLE;
        end
      end
      KRWLT_IDLE: begin
        if (start_i) begin
          state_d = is_global_i ? KRWLT_EXEC : KRWLT_SCAN;
        end
      end
      KRWLT_SCAN: begin
        if (stat_i.addr_last) begin
          state_d = KRWLT_DRAIN;
        end
      end
      KRWLT_DRAIN: state_d = KRWLT_EXEC;
      KRWLT_EXEC:  state_d = KRWLT_IDLE;
      default:     state_d = KRWLT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      KRWLT_CLEAR: cmd_o.clear = 1'b1;
      KRWLT_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      KRWLT_SCAN:  cmd_o.scan = 1'b1;
      KRWLT_DRAIN: cmd_o      = '0;
      KRWLT_EXEC:  cmd_o.exec = 1'b1;
      default:     cmd_o      = '0;
    endcase
  end

endmodule

[design/krwlt_datapath.sv]
// ----------------------------------------------------------------------------
// krwlt_datapath
// Entry memory, scan match/free tracking, global counts, totals and result.
// ----------------------------------------------------------------------------
module krwlt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_BITS      = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  krwlt_pkg::krwlt_cmd_t                 cmd_i,
  output krwlt_pkg::krwlt_stat_t                stat_o,
  input  logic [1:0]                            opcode_i,
  input  logic [krwlt_pkg::KEY_PORT_W-1:0]      key_i,
  input  logic                                  is_global_i,
  output logic                                  done_o,
  output logic                                  granted_o,
  output logic [2:0]                            status_o,
  output logic [krwlt_pkg::CNT_PORT_W-1:0]      key_readers_o,
  output logic [krwlt_pkg::CNT_PORT_W-1:0]      key_writers_o
);
  import krwlt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] rd;
    logic [COUNT_BITS-1:0] wr;
  } entry_t;

  // entry storage
  entry_t mem_q [TABLE_ENTRIES];
  entry_t rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // request
  logic [1:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic                glob_q;

  // scan
  logic [IDX_W-1:0] addr_q;
  logic             rvalid_q;
  logic [IDX_W-1:0] ridx_q;
  logic             match_found_q, free_found_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0] m_rd_q, m_wr_q;
  logic             hit, hole;

  // counts
  logic [COUNT_BITS-1:0] g_rd_q, g_wr_q, tot_rd_q, tot_wr_q;
  logic [COUNT_BITS-1:0] g_rd_d, g_wr_d;

  // decision
  logic                  is_read, is_lock, gheld, conflict;
  logic [COUNT_BITS-1:0] sel_tot, sel_g, cur, mine, new_rd, new_wr;
  logic [COUNT_BITS-1:0] res_rd, res_wr;
  logic                  tot_inc, tot_dec;
  logic [2:0]            status_d;
  logic                  ent_we;
  logic [IDX_W-1:0]      ent_idx;
  entry_t                ent_data;
  logic [COUNT_BITS+CNT_PORT_W-1:0] rd_ext, wr_ext;

  assign stat_o.addr_last = (addr_q == LAST_IDX);

  // memory: one write port, one registered read port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.exec) begin
      mem_we    = ent_we;
      mem_waddr = ent_idx;
      mem_wdata = ent_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  assign hit  = rvalid_q && rdata_q.valid && (rdata_q.key == key_q) && !match_found_q;
  assign hole = rvalid_q && !rdata_q.valid && !free_found_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q        <= '0;
      rvalid_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      g_rd_q        <= '0;
      g_wr_q        <= '0;
      tot_rd_q      <= '0;
      tot_wr_q      <= '0;
      done_o        <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.scan;
      done_o   <= cmd_i.exec;
      if (cmd_i.load) begin
        addr_q        <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan || cmd_i.clear) begin
          addr_q <= addr_q + 1'b1;
        end
        if (hit) begin
          match_found_q <= 1'b1;
        end
        if (hole) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.exec) begin
        g_rd_q <= g_rd_d;
        g_wr_q <= g_wr_d;
        if (tot_inc) begin
          if (is_read) begin
            tot_rd_q <= tot_rd_q + CNT_ONE;
          end else begin
            tot_wr_q <= tot_wr_q + CNT_ONE;
          end
        end
        if (tot_dec) begin
          if (is_read && tot_rd_q != CNT_ZERO) begin
            tot_rd_q <= tot_rd_q - CNT_ONE;
          end else if (!is_read && tot_wr_q != CNT_ZERO) begin
            tot_wr_q <= tot_wr_q - CNT_ONE;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      key_q  <= key_i[KEY_BITS-1:0];
      glob_q <= is_global_i;
    end
    ridx_q <= addr_q;
    if (hit) begin
      match_idx_q <= ridx_q;
      m_rd_q      <= rdata_q.rd;
      m_wr_q      <= rdata_q.wr;
    end
    if (hole) begin
      free_idx_q <= ridx_q;
    end
    if (cmd_i.exec) begin
      granted_o     <= (status_d == ST_DONE);
      status_o      <= status_d;
      key_readers_o <= rd_ext[CNT_PORT_W-1:0];
      key_writers_o <= wr_ext[CNT_PORT_W-1:0];
    end
  end

  // request decision
  always_comb begin
    is_read  = (op_q == OP_RD_LOCK) || (op_q == OP_RD_UNLOCK);
    is_lock  = (op_q == OP_RD_LOCK) || (op_q == OP_WR_LOCK);
    sel_tot  = is_read ? tot_rd_q : tot_wr_q;
    sel_g    = is_read ? g_rd_q : g_wr_q;
    gheld    = (g_rd_q != CNT_ZERO) || (g_wr_q != CNT_ZERO);
    conflict = 1'b0;
    cur      = CNT_ZERO;
    mine     = is_read ? m_rd_q : m_wr_q;
    new_rd   = m_rd_q;
    new_wr   = m_wr_q;
    status_d = ST_DONE;
    tot_inc  = 1'b0;
    tot_dec  = 1'b0;
    g_rd_d   = g_rd_q;
    g_wr_d   = g_wr_q;
    ent_we   = 1'b0;
    ent_idx  = match_idx_q;
    ent_data = '{valid: 1'b1, key: key_q, rd: m_rd_q, wr: m_wr_q};
    res_rd   = match_found_q ? m_rd_q : CNT_ZERO;
    res_wr   = match_found_q ? m_wr_q : CNT_ZERO;

    if (glob_q) begin
      if (is_lock) begin
        conflict = is_read ? (tot_wr_q != CNT_ZERO)
                           : ((tot_rd_q != CNT_ZERO) || (tot_wr_q != CNT_ZERO));
        if (conflict) begin
          status_d = ST_CONFLICT;
        end else if (sel_g == CNT_MAX || sel_tot == CNT_MAX) begin
          status_d = ST_LIMIT;
        end else begin
          tot_inc = 1'b1;
          if (is_read) begin
            g_rd_d = g_rd_q + CNT_ONE;
          end else begin
            g_wr_d = g_wr_q + CNT_ONE;
          end
        end
      end else begin
        if (sel_g == CNT_ZERO) begin
          status_d = ST_NOT_HELD;
        end else begin
          tot_dec = 1'b1;
          if (is_read) begin
            g_rd_d = g_rd_q - CNT_ONE;
          end else begin
            g_wr_d = g_wr_q - CNT_ONE;
          end
        end
      end
      res_rd = g_rd_d;
      res_wr = g_wr_d;
    end else if (is_lock) begin
      // key lock: global holder or existing entry decides the conflict
      if (!is_read) begin
        conflict = gheld || match_found_q;
      end else if (gheld) begin
        conflict = (g_wr_q != CNT_ZERO);
      end else begin
        conflict = match_found_q && (m_wr_q != CNT_ZERO);
      end
      if (conflict) begin
        status_d = ST_CONFLICT;
      end else if (!match_found_q && !free_found_q) begin
        status_d = ST_FULL;
      end else begin
        cur = match_found_q ? mine : CNT_ZERO;
        if (cur == CNT_MAX || sel_tot == CNT_MAX) begin
          status_d = ST_LIMIT;
        end else begin
          new_rd   = (match_found_q ? m_rd_q : CNT_ZERO) + (is_read ? CNT_ONE : CNT_ZERO);
          new_wr   = (match_found_q ? m_wr_q : CNT_ZERO) + (is_read ? CNT_ZERO : CNT_ONE);
          tot_inc  = 1'b1;
          ent_we   = 1'b1;
          ent_idx  = match_found_q ? match_idx_q : free_idx_q;
          ent_data = '{valid: 1'b1, key: key_q, rd: new_rd, wr: new_wr};
          res_rd   = new_rd;
          res_wr   = new_wr;
        end
      end
    end else begin
      // key unlock: free the entry once both counts reach zero
      if (!match_found_q || mine == CNT_ZERO) begin
        status_d = ST_NOT_HELD;
      end else begin
        new_rd   = m_rd_q - (is_read ? CNT_ONE : CNT_ZERO);
        new_wr   = m_wr_q - (is_read ? CNT_ZERO : CNT_ONE);
        tot_dec  = 1'b1;
        ent_we   = 1'b1;
        ent_data = '{valid: 1'b1, key: key_q, rd: new_rd, wr: new_wr};
        res_rd   = new_rd;
        res_wr   = new_wr;
        if (new_rd == CNT_ZERO && new_wr == CNT_ZERO) begin
          ent_data.valid = 1'b0;
        end
      end
    end
    rd_ext = {{CNT_PORT_W{1'b0}}, res_rd};
    wr_ext = {{CNT_PORT_W{1'b0}}, res_wr};
  end

endmodule

[design/keyed_reader_writer_lock_table.sv]
// ----------------------------------------------------------------------------
// keyed_reader_writer_lock_table
// Lock manager table with per-key and global reader/writer counts.
// ----------------------------------------------------------------------------
// A request (opcode, key, is_global) transfers at a clock edge with start_i
// high and busy_o low. After reset the block first invalidates every table
// entry, one per cycle, and holds busy_o high through that pass. A key
// request then scans the whole table through the single read port of the
// entry memory, one entry per cycle, then decides and registers its result;
// a global request skips the scan. Each request gives exactly one result,
// shown for one cycle with done_o high; the receiver cannot stall it, and a
// new request may transfer in the same cycle the result is shown. Locks that
// would block are denied with a conflict status for the requester to retry.
// ----------------------------------------------------------------------------
module keyed_reader_writer_lock_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_BITS      = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       opcode_i,
  input  logic [krwlt_pkg::KEY_PORT_W-1:0] key_i,
  input  logic                             is_global_i,
  // result
  output logic                             done_o,
  output logic                             granted_o,
  output logic [2:0]                       status_o,
  output logic [krwlt_pkg::CNT_PORT_W-1:0] key_readers_o,
  output logic [krwlt_pkg::CNT_PORT_W-1:0] key_writers_o
);
  import krwlt_pkg::*;

  krwlt_cmd_t  cmd;
  krwlt_stat_t stat;

  // sequencer: clear pass, scan, execute
  krwlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .is_global_i (is_global_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // table memory, counts and result registers
  krwlt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .is_global_i   (is_global_i),
    .done_o        (done_o),
    .granted_o     (granted_o),
    .status_o      (status_o),
    .key_readers_o (key_readers_o),
    .key_writers_o (key_writers_o)
  );

endmodule

[design/krwlt_checker.sv]
// ----------------------------------------------------------------------------
// krwlt_checker
// Port-level checks on request/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module krwlt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic                             granted_o,
  input logic [2:0]                       status_o,
  input logic [krwlt_pkg::CNT_PORT_W-1:0] key_readers_o,
  input logic [krwlt_pkg::CNT_PORT_W-1:0] key_writers_o
);
  import krwlt_pkg::*;

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request transfer not followed by busy");

  // a result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // results never come back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // grant agrees with status
  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (granted_o == (status_o == ST_DONE)))
    else $error("granted disagrees with status");

  // a full table never reports an entry
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> (key_readers_o == '0) && (key_writers_o == '0))
    else $error("table full result with nonzero counts");

endmodule

bind keyed_reader_writer_lock_table krwlt_checker u_krwlt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .granted_o     (granted_o),
  .status_o      (status_o),
  .key_readers_o (key_readers_o),
  .key_writers_o (key_writers_o)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed reader/writer lock table. Requests go in
// through the start/busy command port; every result strobed on done_o is
// checked field by field against an in-bench lock table model that is updated
// at each transfer. Directed tests hit the lock rules and a full table; random
// traffic then fills and drains the table in phases.
// ----------------------------------------------------------------------------
module tb_top;
  import krwlt_pkg::*;

  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned KEY_W      = KEY_PORT_W;
  localparam int unsigned CNT_W      = CNT_PORT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one result as seen on the result ports
  typedef struct packed {
    logic             granted;
    logic [2:0]       status;
    logic [CNT_W-1:0] readers;
    logic [CNT_W-1:0] writers;
  } lock_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic [1:0]       opcode_i    = OP_RD_LOCK;
  logic [KEY_W-1:0] key_i       = '0;
  logic             is_global_i = 1'b0;
  logic             busy_o;
  logic             done_o;
  logic             granted_o;
  logic [2:0]       status_o;
  logic [CNT_W-1:0] key_readers_o;
  logic [CNT_W-1:0] key_writers_o;

  // lock table model, updated at each request transfer
  logic             tbl_valid [TABLE_SIZE];
  logic [KEY_W-1:0] tbl_key   [TABLE_SIZE];
  logic [CNT_W-1:0] tbl_rd    [TABLE_SIZE];
  logic [CNT_W-1:0] tbl_wr    [TABLE_SIZE];
  logic [CNT_W-1:0] glb_rd, glb_wr;
  logic [CNT_W-1:0] sum_rd, sum_wr;

  // results still owed by the block, oldest first
  lock_result_t pending_results [$];
  int unsigned  error_count = 0;

  keyed_reader_writer_lock_table #(
    .TABLE_ENTRIES(TABLE_SIZE),
    .KEY_BITS     (KEY_W),
    .COUNT_BITS   (CNT_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .is_global_i  (is_global_i),
    .done_o       (done_o),
    .granted_o    (granted_o),
    .status_o     (status_o),
    .key_readers_o(key_readers_o),
    .key_writers_o(key_writers_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // lock table model: applies one request and returns the result it gives
  // --------------------------------------------------------------------------
  function automatic lock_result_t predict_lock_result(logic [1:0] op, logic [KEY_W-1:0] key,
                                                       logic glob);
    lock_result_t     res;
    logic             is_read, is_lock, conflict, gheld, fresh;
    logic [CNT_W-1:0] cur, tot;
    int               idx, i;
    is_read = (op == OP_RD_LOCK) || (op == OP_RD_UNLOCK);
    is_lock = (op == OP_RD_LOCK) || (op == OP_WR_LOCK);
    tot = is_read ? sum_rd : sum_wr;
    res.status  = ST_DONE;
    res.readers = '0;
    res.writers = '0;
    if (glob) begin
      // global key lives outside the table
      cur = is_read ? glb_rd : glb_wr;
      if (is_lock) begin
        conflict = is_read ? (sum_wr != 0) : (sum_rd != 0 || sum_wr != 0);
        if (conflict) begin
          res.status = ST_CONFLICT;
        end else if (cur == CNT_MAX || tot == CNT_MAX) begin
          res.status = ST_LIMIT;
        end else begin
          cur++;
          tot++;
        end
      end else if (cur == 0) begin
        res.status = ST_NOT_HELD;
      end else begin
        cur--;
        if (tot != 0) tot--;
      end
      if (is_read) begin
        glb_rd = cur;
        sum_rd = tot;
      end else begin
        glb_wr = cur;
        sum_wr = tot;
      end
      res.readers = glb_rd;
      res.writers = glb_wr;
    end else begin
      idx = -1;
      for (i = 0; i < TABLE_SIZE; i++)
        if (idx < 0 && tbl_valid[i] && tbl_key[i] == key) idx = i;
      if (is_lock) begin
        gheld = (glb_rd != 0) || (glb_wr != 0);
        if (!is_read) conflict = gheld || idx >= 0;
        else if (gheld) conflict = (glb_wr != 0);
        else conflict = (idx >= 0) && (tbl_wr[idx] != 0);
        if (conflict) begin
          res.status = ST_CONFLICT;
        end else begin
          fresh = (idx < 0);
          if (fresh) begin
            // lowest free entry takes a new key
            for (i = 0; i < TABLE_SIZE; i++)
              if (idx < 0 && !tbl_valid[i]) idx = i;
            if (idx < 0) res.status = ST_FULL;
          end
          if (res.status == ST_DONE) begin
            cur = fresh ? '0 : (is_read ? tbl_rd[idx] : tbl_wr[idx]);
            if (cur == CNT_MAX || tot == CNT_MAX) begin
              res.status = ST_LIMIT;
              if (fresh) idx = -1;
            end else begin
              if (fresh) begin
                tbl_valid[idx] = 1'b1;
                tbl_key[idx]   = key;
                tbl_rd[idx]    = '0;
                tbl_wr[idx]    = '0;
              end
              if (is_read) tbl_rd[idx]++;
              else tbl_wr[idx]++;
              tot++;
            end
          end
        end
      end else if (idx < 0 || (is_read ? tbl_rd[idx] : tbl_wr[idx]) == 0) begin
        res.status = ST_NOT_HELD;
      end else begin
        if (is_read) tbl_rd[idx]--;
        else tbl_wr[idx]--;
        if (tot != 0) tot--;
        // entry is freed once nobody holds it
        if (tbl_rd[idx] == 0 && tbl_wr[idx] == 0) begin
          tbl_valid[idx] = 1'b0;
          idx = -1;
        end
      end
      if (is_read) sum_rd = tot;
      else sum_wr = tot;
      if (idx >= 0) begin
        if (tbl_valid[idx]) begin
          res.readers = tbl_rd[idx];
          res.writers = tbl_wr[idx];
        end
      end
    end
    res.granted = (res.status == ST_DONE);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: idles gap cycles, then holds start until the transfer
  // --------------------------------------------------------------------------
  task automatic issue_request(logic [1:0] op, logic [KEY_W-1:0] key, logic glob, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i    = op;
    key_i       = key;
    is_global_i = glob;
    start_i     = 1'b1;
    // busy only moves at rising edges, so a low busy here means transfer next edge
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(predict_lock_result(op, key, glob));
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // result checker: every strobe must match the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    lock_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with none owed: granted=%0d status=%0d rd=%0d wr=%0d",
                   $time, granted_o, status_o, key_readers_o, key_writers_o);
      end else begin
        want = pending_results.pop_front();
        if (granted_o !== want.granted || status_o !== want.status ||
            key_readers_o !== want.readers || key_writers_o !== want.writers) begin
          error_count++;
          if (error_count <= 10) begin
            $write("%0t: mismatch exp granted=%0d status=%0d rd=%0d wr=%0d", $time,
                   want.granted, want.status, want.readers, want.writers);
            $display(" got granted=%0d status=%0d rd=%0d wr=%0d",
                     granted_o, status_o, key_readers_o, key_writers_o);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed: lock rules for keys and the global key, key 0 and all-ones key
  // --------------------------------------------------------------------------
  task automatic test_basic_ops();
    logic [KEY_W-1:0] k_min, k_max, k_mid;
    k_min = '0;
    k_max = '1;
    k_mid = 64'hA5A5_5A5A_C3C3_3C3C;
    issue_request(OP_RD_LOCK,   k_min, 1'b0, $urandom_range(0, 3));  // new entry
    issue_request(OP_RD_LOCK,   k_min, 1'b0, $urandom_range(0, 3));  // second reader
    issue_request(OP_WR_LOCK,   k_min, 1'b0, $urandom_range(0, 3));  // entry exists
    issue_request(OP_WR_UNLOCK, k_min, 1'b0, $urandom_range(0, 3));  // no writer held
    issue_request(OP_RD_UNLOCK, k_min, 1'b0, $urandom_range(0, 3));
    issue_request(OP_RD_UNLOCK, k_min, 1'b0, $urandom_range(0, 3));  // entry freed
    issue_request(OP_RD_UNLOCK, k_min, 1'b0, $urandom_range(0, 3));  // no entry
    issue_request(OP_WR_LOCK,   k_max, 1'b0, $urandom_range(0, 3));  // all-ones is a plain key
    issue_request(OP_RD_LOCK,   k_max, 1'b0, $urandom_range(0, 3));  // key has a writer
    issue_request(OP_WR_LOCK,   k_max, 1'b0, $urandom_range(0, 3));
    issue_request(OP_RD_LOCK,   k_max, 1'b1, $urandom_range(0, 3));  // global read vs writer
    issue_request(OP_WR_UNLOCK, k_max, 1'b0, $urandom_range(0, 3));
    issue_request(OP_WR_UNLOCK, k_max, 1'b0, $urandom_range(0, 3));
    issue_request(OP_WR_UNLOCK, k_mid, 1'b1, $urandom_range(0, 3));  // global not held
    issue_request(OP_WR_LOCK,   k_mid, 1'b1, $urandom_range(0, 3));  // empty table
    issue_request(OP_RD_LOCK,   k_max, 1'b1, $urandom_range(0, 3));
    issue_request(OP_RD_LOCK,   k_mid, 1'b0, $urandom_range(0, 3));  // global writer blocks
    issue_request(OP_WR_LOCK,   k_min, 1'b1, $urandom_range(0, 3));
    issue_request(OP_WR_UNLOCK, k_min, 1'b1, $urandom_range(0, 3));
    issue_request(OP_RD_LOCK,   k_min, 1'b1, $urandom_range(0, 3));
    issue_request(OP_RD_LOCK,   k_mid, 1'b0, $urandom_range(0, 3));  // shares global read
    issue_request(OP_WR_LOCK,   k_mid, 1'b0, $urandom_range(0, 3));  // global is held
    issue_request(OP_WR_LOCK,   k_mid, 1'b1, $urandom_range(0, 3));  // readers present
    issue_request(OP_RD_UNLOCK, k_max, 1'b1, $urandom_range(0, 3));
    issue_request(OP_RD_UNLOCK, k_mid, 1'b0, $urandom_range(0, 3));
  endtask

  // --------------------------------------------------------------------------
  // directed: every entry taken, a new key is refused, then all released
  // --------------------------------------------------------------------------
  task automatic test_table_full();
    logic [KEY_W-1:0] held_keys [TABLE_SIZE + 1];
    int               i;
    for (i = 0; i <= TABLE_SIZE; i++)
      held_keys[i] = {5'(i), $urandom(), 27'($urandom())};
    for (i = 0; i < TABLE_SIZE; i++)
      issue_request(i[0] ? OP_WR_LOCK : OP_RD_LOCK, held_keys[i], 1'b0, $urandom_range(0, 3));
    issue_request(OP_RD_LOCK, held_keys[TABLE_SIZE], 1'b0, $urandom_range(0, 3));
    issue_request(OP_WR_LOCK, held_keys[TABLE_SIZE], 1'b0, $urandom_range(0, 3));
    // an existing key still gets another reader on a full table
    issue_request(OP_RD_LOCK, held_keys[0], 1'b0, $urandom_range(0, 3));
    issue_request(OP_RD_UNLOCK, held_keys[0], 1'b0, $urandom_range(0, 3));
    for (i = 0; i < TABLE_SIZE; i++)
      issue_request(i[0] ? OP_WR_UNLOCK : OP_RD_UNLOCK, held_keys[i], 1'b0,
                    $urandom_range(0, 3));
  endtask

  // --------------------------------------------------------------------------
  // random traffic: phases that lean toward locking or unlocking, so the table
  // fills up and drains; unlocks mostly release what is really held
  // --------------------------------------------------------------------------
  task automatic test_random_traffic();
    logic [KEY_W-1:0] key_pool [20];
    logic [KEY_W-1:0] key;
    logic [1:0]       op;
    logic             glob;
    int               held [$];
    int               blk, n, i, pick, slot, lock_bias, gap_max;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0001;
    for (i = 3; i < 20; i++) key_pool[i] = {$urandom(), $urandom()};
    for (blk = 0; blk < 31; blk++) begin
      lock_bias = $urandom_range(20, 85);
      gap_max   = (blk % 4 == 1) ? 0 : 3;  // some phases run back to back
      for (n = 0; n < 50; n++) begin
        held.delete();
        for (i = 0; i < TABLE_SIZE; i++)
          if (tbl_valid[i]) held.push_back(i);
        pick = $urandom_range(0, 99);
        glob = 1'b0;
        key  = key_pool[$urandom_range(0, 19)];
        if (pick < 6) begin
          // noise: anything at all
          op   = 2'($urandom());
          glob = 1'($urandom());
          key  = {$urandom(), $urandom()};
        end else if (pick >= 30 && pick < 36) begin
          glob = 1'b1;
          key  = {$urandom(), $urandom()};
          op   = ($urandom_range(0, 2) == 0) ? OP_WR_LOCK : OP_RD_LOCK;
        end else if ((glb_rd != 0 || glb_wr != 0) && pick < 30) begin
          // release the global key soon so key traffic can go on
          glob = 1'b1;
          key  = {$urandom(), $urandom()};
          op   = (glb_wr != 0) ? OP_WR_UNLOCK : OP_RD_UNLOCK;
        end else if ($urandom_range(0, 99) < lock_bias || held.size() == 0) begin
          op = ($urandom_range(0, 3) == 0) ? OP_WR_LOCK : OP_RD_LOCK;
        end else begin
          slot = held[$urandom_range(0, held.size() - 1)];
          key  = tbl_key[slot];
          op   = (tbl_wr[slot] != 0) ? OP_WR_UNLOCK : OP_RD_UNLOCK;
        end
        issue_request(op, key, glob, $urandom_range(0, gap_max));
      end
      if (blk % 5 == 4) wait_results_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int i;
    for (i = 0; i < TABLE_SIZE; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_rd[i]    = '0;
      tbl_wr[i]    = '0;
    end
    glb_rd = '0;
    glb_wr = '0;
    sum_rd = '0;
    sum_wr = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // the block clears its table after reset; the driver waits on busy
    test_basic_ops();
    wait_results_drained();
    test_table_full();
    wait_results_drained();
    test_random_traffic();
    wait_results_drained();
    // a key request spans a full table scan; allow that much for stray strobes
    repeat (TABLE_SIZE + 8) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
